// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the key-value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LKV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// Check that a condition never holds outside reset.
`define LKV_NEVER(lbl, clk, rstn, cond) \
  `LKV_ASSERT(lbl, clk, rstn, !(cond))

`endif

// File: rtl/lkv_pkg.sv
// Package with the types and constants of the key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [KEY_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMMIT
  } lkv_state_e;

  // Control strobes from the sequencer to the row of cells
  typedef struct packed {
    logic ready;   // take a new item
    logic look;    // register the compare results
    logic commit;  // write the result, update the row
    logic shift;   // move entries one cell towards the tail
    logic evict;   // the tail entry drops off the row
  } lkv_ctl_t;

endpackage

// File: rtl/lkv_req_if.sv
// Request channel interface: operation, key and value.
`timescale 1ns / 1ps
interface lkv_req_if;
  import lkv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// File: rtl/lkv_rsp_if.sv
// Response channel interface: hit, read value and eviction report.
`timescale 1ns / 1ps
interface lkv_rsp_if;
  import lkv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [KEY_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// File: rtl/lkv_cell.sv
// One cell of the recency-ordered row: holds a key and a value.
`timescale 1ns / 1ps
module lkv_cell import lkv_pkg::*; (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             live_i,
  input  logic [KEY_W-1:0] probe_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] value_i,
  output logic [KEY_W-1:0] key_o,
  output logic [KEY_W-1:0] value_o,
  output logic             match_o
);

  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] value_q;

  // Take the entry of the neighbour nearer the head
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Compare the probe key with the local entry
  assign match_o = live_i && (key_q == probe_i);
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

// File: rtl/lkv_ctrl.sv
// Sequencer: capacity register, entry count and per-item update decision.
`timescale 1ns / 1ps
module lkv_ctrl import lkv_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_fire_i,
  input  logic             op_i,
  input  logic             hit_i,
  input  logic [IW-1:0]    hit_idx_i,
  input  logic             out_free_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output lkv_ctl_t         ctl_o,
  output logic [IW-1:0]    limit_o,
  output logic [CW-1:0]    count_o
);

  lkv_state_e       state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ecap;
  logic             full;

  // Clamp the capacity to the built depth, zero acts as one
  always_comb begin
    if (cap_q == '0) begin
      ecap = CW'(1);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      ecap = CW'(MAX_ENTRIES);
    end else begin
      ecap = CW'(cap_q);
    end
  end

  assign full = (count_q >= ecap);

  // Next state, strobes and shift limit
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    limit_o = hit_idx_i;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        ctl_o.ready = 1'b1;
        if (req_fire_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl_o.look = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free_i) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
          if (hit_i) begin
            ctl_o.shift = 1'b1;
          end else if (op_i == OP_PUT) begin
            ctl_o.shift = 1'b1;
            if (full) begin
              ctl_o.evict = 1'b1;
              limit_o     = IW'(ecap - CW'(1));
            end else begin
              limit_o = IW'(count_q);
              count_d = count_q + CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A capacity write empties the store
    if (cfg_we_i) begin
      count_d = '0;
    end
  end

  // Hold state, capacity and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/lru_key_value_cache.sv
// Fully associative key-value cache with LRU replacement, top level.
// An item goes through accept, a registered key compare in every cell,
// then commit of the result and a one-step shift of the recency row.
// The result is registered on commit, and no new item is accepted before
// that commit. A waiting result stalls the next commit, and so the input.
// Reset empties the store and sets the capacity to sixteen; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lkv_req_if.sink          req_i,
  lkv_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  lkv_ctl_t         ctl;
  logic [IW-1:0]    limit;
  logic [CW-1:0]    count;
  logic             req_fire;
  logic             out_free;

  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] val_q;

  logic             hit_q;
  logic [IW-1:0]    hit_idx_q;
  logic [KEY_W-1:0] hit_val_q;
  logic [KEY_W-1:0] lru_key_q;

  logic [MAX_ENTRIES-1:0] match;
  logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];
  logic [KEY_W-1:0]       cell_val [MAX_ENTRIES];
  logic [IW-1:0]          enc;
  logic [KEY_W-1:0]       orv;
  logic [KEY_W-1:0]       head_val;

  logic             out_valid_q;
  logic             out_hit_q;
  logic [KEY_W-1:0] out_rd_q;
  logic             out_ev_q;
  logic [KEY_W-1:0] out_evk_q;

  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = ctl.ready;

  lkv_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (req_fire),
    .op_i       (op_q),
    .hit_i      (hit_q),
    .hit_idx_i  (hit_idx_q),
    .out_free_i (out_free),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .ctl_o      (ctl),
    .limit_o    (limit),
    .count_o    (count)
  );

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
  end

  // The head cell takes the touched or new entry
  assign head_val = (op_q == OP_PUT) ? val_q : hit_val_q;

  // Row of cells, head is most recent, valid cells sit below the count
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic             live;
    logic             shift;
    logic [KEY_W-1:0] nb_key;
    logic [KEY_W-1:0] nb_val;

    assign live  = (CW'(i) < count);
    assign shift = ctl.shift && (IW'(i) <= limit);

    if (i == 0) begin : g_head
      assign nb_key = key_q;
      assign nb_val = head_val;
    end else begin : g_body
      assign nb_key = cell_key[i-1];
      assign nb_val = cell_val[i-1];
    end

    lkv_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .live_i  (live),
      .probe_i (key_q),
      .key_i   (nb_key),
      .value_i (nb_val),
      .key_o   (cell_key[i]),
      .value_o (cell_val[i]),
      .match_o (match[i])
    );
  end

  // Encode the single matching cell and pick its value
  always_comb begin
    enc = '0;
    orv = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        enc = enc | IW'(i);
        orv = orv | cell_val[i];
      end
    end
  end

  // Register the compare results and the tail key
  always_ff @(posedge clk_i) begin
    if (ctl.look) begin
      hit_q     <= |match;
      hit_idx_q <= enc;
      hit_val_q <= orv;
      lru_key_q <= cell_key[IW'(count - CW'(1))];
    end
  end

  // Output register, filled on commit and drained by the sink
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      out_hit_q <= hit_q;
      out_ev_q  <= ctl.evict;
      out_evk_q <= ctl.evict ? lru_key_q : '0;
      if (op_q == OP_PUT) begin
        out_rd_q <= '0;
      end else begin
        out_rd_q <= hit_q ? hit_val_q : MISS_VALUE;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.evicted     = out_ev_q;
  assign rsp_o.evicted_key = out_evk_q;

  // Checks
  `LKV_ASSERT(a_count_bound, clk_i, rst_ni, count <= CW'(MAX_ENTRIES))
  `LKV_ASSERT(a_one_in_flight, clk_i, rst_ni, req_fire |=> !req_i.ready)
  `LKV_ASSERT(a_hit_in_row, clk_i, rst_ni, (ctl.commit && hit_q) |-> (CW'(hit_idx_q) < count))
  `LKV_NEVER(a_evict_on_hit, clk_i, rst_ni, ctl.evict && hit_q)

endmodule

// File: tb/sv/lru_key_value_cache_tb.sv
// Testbench for the LRU key-value cache: directed table, then random checked items.
`timescale 1ns / 1ps
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int unsigned CACHE_DEPTH    = 16;
  localparam int unsigned SEGMENTS       = 8;
  localparam int unsigned SEGMENT_ITEMS  = 135;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } response_t;

  typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    logic [CAP_W-1:0] capacity;
    logic             typed;
    response_t        want;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_data_i;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache #(
    .MAX_ENTRIES(CACHE_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_o     (rsp_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  // Cache image kept by the predictor
  logic [KEY_W-1:0] model_keys  [CACHE_DEPTH];
  logic [KEY_W-1:0] model_vals  [CACHE_DEPTH];
  bit               model_valid [CACHE_DEPTH];
  int unsigned      model_rank  [CACHE_DEPTH];
  int unsigned      model_count;
  logic [CAP_W-1:0] model_capacity;

  response_t   expected_responses[$];
  row_t        directed_rows[$];

  // Typed expectation that travels with the item on offer
  logic        offer_typed;
  response_t   offer_want;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned items_accepted;
  int unsigned responses_checked;
  int unsigned hits_seen;
  int unsigned evictions_seen;
  int unsigned capacity_writes;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic void clear_model();
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      model_valid[i] = 1'b0;
      model_rank[i]  = 0;
    end
    model_count = 0;
  endfunction

  // Work out the response of one access and update the cache image
  function automatic response_t predict_access(logic op, logic [KEY_W-1:0] key,
                                               logic [KEY_W-1:0] value);
    response_t   r;
    int          found;
    int          oldest;
    int          slot;
    int unsigned prior;
    int unsigned limit;
    r      = '0;
    found  = -1;
    oldest = -1;
    slot   = -1;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (found < 0 && model_valid[i] && model_keys[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == OP_GET) r.read_value = model_vals[found];
      else model_vals[found] = value;
      // Promote to most recent; younger entries age by one
      prior = model_rank[found];
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (model_valid[i] && model_rank[i] < prior) model_rank[i]++;
      end
      model_rank[found] = 0;
    end else if (op == OP_GET) begin
      r.read_value = MISS_VALUE;
    end else begin
      limit = (model_capacity == 0) ? 1 :
              (model_capacity > CACHE_DEPTH) ? CACHE_DEPTH : model_capacity;
      // Drop the least recent entry when full
      if (model_count >= limit && model_count > 0) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (model_valid[i] && (oldest < 0 || model_rank[i] > model_rank[oldest])) oldest = i;
        end
        if (oldest >= 0) begin
          r.evicted          = 1'b1;
          r.evicted_key      = model_keys[oldest];
          model_valid[oldest] = 1'b0;
          model_count--;
        end
      end
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (slot < 0 && !model_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (model_valid[i]) model_rank[i]++;
        end
        model_keys[slot]  = key;
        model_vals[slot]  = value;
        model_valid[slot] = 1'b1;
        model_rank[slot]  = 0;
        model_count++;
      end
    end
    return r;
  endfunction

  function automatic row_t row_item(logic op, logic [KEY_W-1:0] key, logic [KEY_W-1:0] value);
    row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  function automatic row_t row_check(logic op, logic [KEY_W-1:0] key, logic [KEY_W-1:0] value,
                                     logic hit, logic [KEY_W-1:0] rd, logic ev,
                                     logic [KEY_W-1:0] evk);
    row_t r;
    r                  = row_item(op, key, value);
    r.typed            = 1'b1;
    r.want.hit         = hit;
    r.want.read_value  = rd;
    r.want.evicted     = ev;
    r.want.evicted_key = evk;
    return r;
  endfunction

  function automatic row_t row_capacity(logic [CAP_W-1:0] capacity);
    row_t r;
    r          = '0;
    r.kind     = ROW_CAPACITY;
    r.capacity = capacity;
    return r;
  endfunction

  task automatic report_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [KEY_W-1:0] value,
                           logic typed, response_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    req_ch.value <= value;
    offer_typed  = typed;
    offer_want   = want;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding response, then let the block settle
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] capacity);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= capacity;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_capacity = capacity;
    clear_model();
    capacity_writes++;
  endtask

  // Response ready: random stalls, with one long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict on each accepted item, check each accepted response
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        want = predict_access(req_ch.op, req_ch.key, req_ch.value);
        expected_responses.push_back(offer_typed ? offer_want : want);
        items_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with nothing expected, got hit %b value %h",
                   $time, rsp_ch.hit, rsp_ch.read_value);
          $display("%0t: evicted %b key %h", $time, rsp_ch.evicted, rsp_ch.evicted_key);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          report_field("hit", KEY_W'(want.hit), KEY_W'(rsp_ch.hit));
          report_field("read_value", want.read_value, rsp_ch.read_value);
          report_field("evicted", KEY_W'(want.evicted), KEY_W'(rsp_ch.evicted));
          report_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
          responses_checked++;
          if (rsp_ch.hit) hits_seen++;
          if (rsp_ch.evicted) evictions_seen++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] seg_caps [SEGMENTS];
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    int unsigned      limit;
    int unsigned      pick;
    row_t             row;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_GET;
    req_ch.key     = '0;
    req_ch.value   = '0;
    offer_typed    = 1'b0;
    offer_want     = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    holds_asked    = 0;
    model_capacity = CAP_RESET;
    clear_model();

    // Extremes after reset, capacity clamps, eviction at capacity one and two
    directed_rows.push_back(row_check(OP_GET, 32'h0000_0000, 32'h1234_5678,
                                      1'b0, MISS_VALUE, 1'b0, 0));
    directed_rows.push_back(row_check(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000,
                                      1'b0, 0, 1'b0, 0));
    directed_rows.push_back(row_check(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF,
                                      1'b0, 0, 1'b0, 0));
    directed_rows.push_back(row_check(OP_GET, 32'h7FFF_FFFF, 32'h0,
                                      1'b1, 32'h8000_0000, 1'b0, 0));
    directed_rows.push_back(row_check(OP_GET, 32'h8000_0000, 32'h0,
                                      1'b1, 32'h7FFF_FFFF, 1'b0, 0));
    directed_rows.push_back(row_check(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                      1'b1, 0, 1'b0, 0));
    directed_rows.push_back(row_check(OP_GET, 32'h7FFF_FFFF, 32'h0,
                                      1'b1, 32'hFFFF_FFFF, 1'b0, 0));
    directed_rows.push_back(row_check(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      1'b0, MISS_VALUE, 1'b0, 0));
    directed_rows.push_back(row_item(OP_PUT, 32'h0000_0000, 32'h0000_0000));
    directed_rows.push_back(row_capacity(5'd0));
    directed_rows.push_back(row_check(OP_GET, 32'h7FFF_FFFF, 32'h0,
                                      1'b0, MISS_VALUE, 1'b0, 0));
    directed_rows.push_back(row_check(OP_PUT, 32'h0000_0001, 32'd11,
                                      1'b0, 0, 1'b0, 0));
    directed_rows.push_back(row_check(OP_PUT, 32'h0000_0002, 32'd22,
                                      1'b0, 0, 1'b1, 32'h0000_0001));
    directed_rows.push_back(row_check(OP_GET, 32'h0000_0001, 32'h0,
                                      1'b0, MISS_VALUE, 1'b0, 0));
    directed_rows.push_back(row_check(OP_GET, 32'h0000_0002, 32'h0,
                                      1'b1, 32'd22, 1'b0, 0));
    directed_rows.push_back(row_capacity(5'd2));
    directed_rows.push_back(row_item(OP_PUT, 32'd10, 32'd100));
    directed_rows.push_back(row_item(OP_PUT, 32'd20, 32'd200));
    directed_rows.push_back(row_item(OP_GET, 32'd10, 32'd0));
    directed_rows.push_back(row_item(OP_PUT, 32'd30, 32'd300));
    directed_rows.push_back(row_item(OP_PUT, 32'd10, 32'd101));
    directed_rows.push_back(row_capacity(5'd31));
    directed_rows.push_back(row_capacity(5'd17));

    seg_caps[0] = 5'd16;
    seg_caps[1] = 5'd1;
    seg_caps[2] = 5'd4;
    seg_caps[3] = 5'd0;
    seg_caps[4] = 5'd31;
    seg_caps[5] = 5'd8;
    seg_caps[6] = 5'd2;
    seg_caps[7] = CAP_W'($urandom_range(31));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CAPACITY) write_capacity(row.capacity);
      else send_item(row.op, row.key, row.value, row.typed, row.want);
    end

    // Random segments, each with its own capacity and one of four idling mixes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_capacity(seg_caps[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      limit = (seg_caps[seg] == 0) ? 1 :
              (seg_caps[seg] > CACHE_DEPTH) ? CACHE_DEPTH : seg_caps[seg];
      // A pool a little larger than the capacity keeps hits and evictions frequent
      key_pool.delete();
      for (int k = 0; k < limit + 3; k++) key_pool.push_back($urandom);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (seg == 4 && n == 40) holds_asked++;
        if (seg == 5 && n == 60) wait_drained();
        pick = $urandom_range(99);
        if (pick < 3) begin
          case ($urandom_range(3))
            0: key = 32'h0000_0000;
            1: key = 32'hFFFF_FFFF;
            2: key = 32'h7FFF_FFFF;
            default: key = 32'h8000_0000;
          endcase
        end else if (pick < 15) begin
          key = $urandom;
        end else begin
          key = key_pool[$urandom_range(key_pool.size() - 1)];
        end
        send_item(logic'($urandom_range(1)), key, $urandom, 1'b0, '0);
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_drained();

    $display("Covered %0d items and %0d responses over %0d capacity writes",
             items_accepted, responses_checked, capacity_writes);
    $display("Saw %0d hits and %0d evictions, with idle, stall and hold-off mixes",
             hits_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: lru_key_value_cache.f
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_req_if.sv
rtl/lkv_rsp_if.sv
rtl/lkv_cell.sv
rtl/lkv_ctrl.sv
rtl/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
